FILE: rtl/dfp_pkg.sv
package dfp_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned WideW    = 2 * DataW;
  localparam int unsigned MulCells = DataW;
  localparam int unsigned DivCells = WideW;
  localparam logic [DataW-1:0] FxScale = 64'd1000000;

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpNeg = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [DataW-1:0]  operand_a;
    logic [DataW-1:0]  operand_b;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  result;
    logic              divide_by_zero;
  } rsp_t;

  // Operand lane through the shift-add multiplier row
  typedef struct packed {
    logic              arith;
    logic              neg;
    logic              dz;
    logic [DataW-1:0]  res;
    logic [DataW-1:0]  x;
    logic [DataW-1:0]  y;
    logic [WideW-1:0]  acc;
    logic [DataW-1:0]  dvsr;
  } mul_lane_t;

  // Operand lane through the restoring divider row
  typedef struct packed {
    logic              arith;
    logic              neg;
    logic              dz;
    logic [DataW-1:0]  res;
    logic [WideW-1:0]  dvd;
    logic [DataW-1:0]  dvsr;
    logic [DataW-1:0]  rem;
    logic [DataW-1:0]  q;
  } div_lane_t;

  function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] v);
    return v[DataW-1] ? (DataW'(0) - v) : v;
  endfunction

endpackage

FILE: rtl/decimal_fixed_point_alu.sv
// Pipeline: 64 multiplier cells, 128 divider cells and one output register;
// the prep logic feeds cell 0.
// Throughput: one request per cycle; every cell stage advances together and
// the whole row holds while a waiting result is stalled.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
module decimal_fixed_point_alu import dfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  logic      en;
  mul_lane_t mul_lane [0:MulCells];
  logic      mul_vld  [0:MulCells];
  div_lane_t div_lane [0:DivCells];
  logic      div_vld  [0:DivCells];
  logic [DataW-1:0] mag_a;
  logic [DataW-1:0] mag_b;
  logic [DataW-1:0] quot;
  logic      out_valid_q;
  rsp_t      out_rsp_q;
  rsp_t      out_rsp_d;

  // Hold the whole row while a finished result waits
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = out_valid_q && out_stall_i;

  // Decode the request into a multiplier lane
  always_comb begin
    mag_a = magnitude(in_req_i.operand_a);
    mag_b = magnitude(in_req_i.operand_b);
    mul_lane[0].arith = 1'b0;
    mul_lane[0].neg   = in_req_i.operand_a[DataW-1] ^ in_req_i.operand_b[DataW-1];
    mul_lane[0].dz    = 1'b0;
    mul_lane[0].res   = '0;
    mul_lane[0].x     = mag_a;
    mul_lane[0].y     = '0;
    mul_lane[0].acc   = '0;
    mul_lane[0].dvsr  = FxScale;
    case (in_req_i.operation)
      OpAdd: mul_lane[0].res = in_req_i.operand_a + in_req_i.operand_b;
      OpSub: mul_lane[0].res = in_req_i.operand_a - in_req_i.operand_b;
      OpNeg: mul_lane[0].res = DataW'(0) - in_req_i.operand_a;
      OpMul: begin
        mul_lane[0].arith = 1'b1;
        mul_lane[0].y     = mag_b;
      end
      OpDiv: begin
        if (in_req_i.operand_b == '0) begin
          mul_lane[0].dz = 1'b1;
        end else begin
          mul_lane[0].arith = 1'b1;
          mul_lane[0].y     = FxScale;
          mul_lane[0].dvsr  = mag_b;
        end
      end
      default: mul_lane[0].res = '0;
    endcase
    mul_vld[0] = in_valid_i;
  end

  // Shift-add multiplier row
  for (genvar i = 0; i < MulCells; i++) begin : g_mul
    dfp_mul_cell #(.Bit(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mul_vld[i]),
      .lane_i  (mul_lane[i]),
      .valid_o (mul_vld[i+1]),
      .lane_o  (mul_lane[i+1])
    );
  end

  // Hand the product to the divider row
  always_comb begin
    div_lane[0].arith = mul_lane[MulCells].arith;
    div_lane[0].neg   = mul_lane[MulCells].neg;
    div_lane[0].dz    = mul_lane[MulCells].dz;
    div_lane[0].res   = mul_lane[MulCells].res;
    div_lane[0].dvd   = mul_lane[MulCells].acc;
    div_lane[0].dvsr  = mul_lane[MulCells].dvsr;
    div_lane[0].rem   = '0;
    div_lane[0].q     = '0;
    div_vld[0]        = mul_vld[MulCells];
  end

  // Restoring divider row, most significant dividend bit first
  for (genvar j = 0; j < DivCells; j++) begin : g_div
    dfp_div_cell #(.Bit(DivCells - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_vld[j]),
      .lane_i  (div_lane[j]),
      .valid_o (div_vld[j+1]),
      .lane_o  (div_lane[j+1])
    );
  end

  // Apply the sign and pick the result
  always_comb begin
    quot = div_lane[DivCells].q;
    out_rsp_d.divide_by_zero = div_lane[DivCells].dz;
    if (div_lane[DivCells].arith) begin
      out_rsp_d.result = div_lane[DivCells].neg ? (DataW'(0) - quot) : quot;
    end else begin
      out_rsp_d.result = div_lane[DivCells].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_vld[DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A zero-divisor result always reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.divide_by_zero |-> out_rsp_q.result == '0)
    else $error("divide_by_zero with nonzero result");

  // The error flag never rides on an arithmetic lane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld[DivCells] && div_lane[DivCells].dz |-> !div_lane[DivCells].arith)
    else $error("error flag on arithmetic lane");

  // A stalled row keeps its last valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(div_vld[DivCells]) && $stable(mul_vld[MulCells]))
    else $error("cell row advanced while held");

endmodule

FILE: rtl/dfp_mul_cell.sv
module dfp_mul_cell import dfp_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  mul_lane_t lane_i,
  output logic      valid_o,
  output mul_lane_t lane_o
);

  mul_lane_t lane_d;
  logic      valid_q;

  // Add one shifted partial product
  always_comb begin
    lane_d = lane_i;
    if (lane_i.y[Bit]) begin
      lane_d.acc = lane_i.acc + ({{DataW{1'b0}}, lane_i.x} << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end

  assign valid_o = valid_q;

endmodule

FILE: rtl/dfp_div_cell.sv
module dfp_div_cell import dfp_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_lane_t lane_i,
  output logic      valid_o,
  output div_lane_t lane_o
);

  div_lane_t        lane_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;
  logic             valid_q;

  // Shift in one dividend bit, subtract divisor when it fits
  always_comb begin
    lane_d = lane_i;
    trial  = {lane_i.rem, lane_i.dvd[Bit]};
    diff   = trial - {1'b0, lane_i.dvsr};
    ge     = (trial >= {1'b0, lane_i.dvsr});
    lane_d.rem = ge ? diff[DataW-1:0] : trial[DataW-1:0];
    lane_d.q   = {lane_i.q[DataW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end

  assign valid_o = valid_q;

endmodule

FILE: test/tb_top.sv
module tb_top;
  import dfp_pkg::*;

  // Scoreboard: predicts each result from an accepted request, checks results in order
  class dfp_scoreboard;
    rsp_t pending_q[$];
    int   n_errors;
    int   n_checked;
    int   n_div_zero;

    function logic [WideW-1:0] wide_mag_prod(logic [DataW-1:0] x, logic [DataW-1:0] y);
      logic [WideW-1:0] p;
      p = {{DataW{1'b0}}, x} * {{DataW{1'b0}}, y};
      return p;
    endfunction

    function rsp_t predict(req_t rq);
      rsp_t r;
      logic [DataW-1:0] ma, mb;
      logic [WideW-1:0] w;
      logic neg;
      r = '0;
      ma = rq.operand_a[DataW-1] ? (64'd0 - rq.operand_a) : rq.operand_a;
      mb = rq.operand_b[DataW-1] ? (64'd0 - rq.operand_b) : rq.operand_b;
      neg = rq.operand_a[DataW-1] ^ rq.operand_b[DataW-1];
      case (rq.operation)
        OpAdd: r.result = rq.operand_a + rq.operand_b;
        OpSub: r.result = rq.operand_a - rq.operand_b;
        OpMul: begin
          w = wide_mag_prod(ma, mb) / {64'd0, 64'd1000000};
          r.result = neg ? (64'd0 - w[DataW-1:0]) : w[DataW-1:0];
        end
        OpDiv: begin
          if (rq.operand_b == '0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            w = wide_mag_prod(ma, 64'd1000000) / {64'd0, mb};
            r.result = neg ? (64'd0 - w[DataW-1:0]) : w[DataW-1:0];
          end
        end
        OpNeg: r.result = 64'd0 - rq.operand_a;
        default: r.result = '0;
      endcase
      return r;
    endfunction

    function void note_request(req_t rq);
      pending_q.push_back(predict(rq));
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, got.result, got.divide_by_zero);
        n_errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      n_checked++;
      if (exp_r.divide_by_zero) n_div_zero++;
      if (got.result !== exp_r.result) begin
        $display("%0t: result mismatch expected %h actual %h", $time, exp_r.result, got.result);
        n_errors++;
      end
      if (got.divide_by_zero !== exp_r.divide_by_zero) begin
        $display("%0t: divide_by_zero mismatch expected %b actual %b", $time,
                 exp_r.divide_by_zero, got.divide_by_zero);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  dfp_scoreboard sb = new();
  bit stim_done = 1'b0;
  int n_sent = 0;

  decimal_fixed_point_alu u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Scale  = 64'd1000000;

  // Send one request, idling a random gap first when gaps is set, and holding until accepted
  task automatic send_request(logic [2:0] opc, logic [63:0] a, logic [63:0] b, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{operation: opc, operand_a: a, operand_b: b};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(in_req_i);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 64'($signed(v[23:0]));
      1: v = 64'($signed(v[39:0]));
      2: v = MinVal;
      3: v = MaxVal;
      4: v = $urandom_range(0, 1) ? Scale : 64'd0 - Scale;
      5: v = 64'($signed(v[11:0]));
      default: ;
    endcase
    return v;
  endfunction

  // Stimulus: directed corners, then random
  initial begin
    logic [2:0] opc;
    logic [63:0] a, b;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_request(OpAdd, MaxVal, 64'd1, 0);
    send_request(OpAdd, MinVal, MinVal, 0);
    send_request(OpSub, MinVal, 64'd1, 0);
    send_request(OpSub, 64'd0, MinVal, 0);
    send_request(OpMul, MaxVal, MaxVal, 0);
    send_request(OpMul, MinVal, MinVal, 0);
    send_request(OpMul, MinVal, Scale, 0);
    send_request(OpMul, 64'd0 - Scale, 64'd999999, 0);
    send_request(OpDiv, 64'd12345, 64'd0, 0);
    send_request(OpDiv, MinVal, 64'd0, 0);
    send_request(OpDiv, MinVal, 64'd0 - Scale, 0);
    send_request(OpDiv, MaxVal, 64'd1, 0);
    send_request(OpDiv, MinVal, MinVal, 0);
    send_request(OpDiv, 64'd0 - 64'd7, 64'd3, 0);
    send_request(OpDiv, 64'd1, MaxVal, 0);
    send_request(OpNeg, MinVal, MaxVal, 0);
    send_request(OpNeg, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_request(3'd5, MaxVal, MaxVal, 0);
    send_request(3'd6, MinVal, 64'd1, 0);
    send_request(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    for (int i = 0; i < 1200; i++) begin
      opc = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      a = rand_operand();
      b = ($urandom_range(0, 19) == 0) ? 64'd0 : rand_operand();
      // Long bursts with no gaps fill the pipe during hold-off
      send_request(opc, a, b, (i % 300) > 100);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall: random per result, one long hold-off early on
  initial begin
    int gap;
    @(posedge rst_ni);
    repeat (30) @(negedge clk_i);
    out_stall_i <= 1'b1;
    repeat (600) @(negedge clk_i);
    forever begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 18);
      if ((n_sent / 250) % 2 == 1) gap = 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (sb.pending_q.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Ran %0d requests through all ops and corners; %0d results checked, %0d div-by-zero",
             n_sent, sb.n_checked, sb.n_div_zero);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
